[design/cnhs_pkg.sv]
package cnhs_pkg;

  // Controller states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CLEAR = 9'b000000010,
    ST_RHS   = 9'b000000100,
    ST_FACT  = 9'b000001000,
    ST_FWD   = 9'b000010000,
    ST_SCALE = 9'b000100000,
    ST_BACK  = 9'b001000000,
    ST_EMIT  = 9'b010000000,
    ST_WAIT  = 9'b100000000
  } state_t;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [1:0] REG_LAMBDA = 2'd0;
  localparam logic [1:0] REG_SRC_LO = 2'd1;
  localparam logic [1:0] REG_SRC_HI = 2'd2;

  // Divider request / response
  typedef struct packed {
    logic        start;
    logic [63:0] num;   // signed numerator
    logic [33:0] den;   // positive denominator
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;   // signed rounded quotient
  } div_rsp_t;

  // Saturate a 66-bit signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7fffffff;
    else if (v < -66'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[design/cnhs_divider.sv]
// Restoring divider, one quotient bit a cycle, rounding ties away from zero
module cnhs_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  cnhs_pkg::div_req_t req,
  output cnhs_pkg::div_rsp_t rsp
);

  logic [63:0] mag_r, mag_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [33:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [34:0] trial;
  logic [63:0] amag;

  always_comb begin
    mag_nxt  = mag_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    amag     = req.num[63] ? (64'd0 - req.num) : req.num;
    trial    = {rem_r[33:0], mag_r[63]} - {1'b0, den_r};
    if (req.start) begin
      // Add half the divisor first so truncation rounds to nearest
      mag_nxt  = amag + {31'd0, req.den[33:1]};
      den_nxt  = req.den;
      neg_nxt  = req.num[63];
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt = {mag_r[62:0], 1'b0};
      if (!trial[34]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[33:0], mag_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? (64'd0 - quo_r) : quo_r;

endmodule

[design/crank_nicolson_heat_step_unit.sv]
// One Crank-Nicolson step of the 1-D heat equation per step request. The field,
// pivots, multipliers and work vector live in simple dual-port memories with a
// registered read port; a sequencer makes five passes over the NODES =
// GRID_INTERVALS-1 interior nodes (right-hand side, factorisation, forward
// substitution, scaling, back substitution) and then streams the new field out
// as NODES result items ending in tlast. Factorisation and scaling use a shared
// bit-serial divider. A clear request zeroes the field with a sweep over all
// NODES nodes and returns nothing. No request is taken while a step or clear is
// running.
module crank_nicolson_heat_step_unit #(
  parameter int GRID_INTERVALS = 32,
  parameter int FRAC_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] source_drive
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] node_index, [37:6] node_value, zero pad
  output logic        out_tlast
);

  localparam int NODES = GRID_INTERVALS - 1;
  localparam int AW    = $clog2(NODES);
  localparam logic [AW-1:0] LASTA = AW'(NODES - 1);

  typedef logic signed [65:0] w_t;

  // Configuration
  logic [23:0] lam_r;
  logic [5:0]  src_lo_r, src_hi_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_r    <= 24'd65536;
      src_lo_r <= 6'd1;
      src_hi_r <= 6'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        cnhs_pkg::REG_LAMBDA: lam_r    <= cfg_data;
        cnhs_pkg::REG_SRC_LO: src_lo_r <= cfg_data[5:0];
        cnhs_pkg::REG_SRC_HI: src_hi_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Memories: field, pivot, multiplier, work
  logic [31:0] fmem [NODES];
  logic [31:0] pmem [NODES];
  logic [31:0] mmem [NODES];
  logic [31:0] wmem [NODES];
  logic [AW-1:0] f_ra, p_ra, m_ra, w_ra, f_wa, p_wa, m_wa, w_wa;
  logic f_we, p_we, m_we, w_we;
  logic [31:0] f_wd, p_wd, m_wd, w_wd, f_rd, p_rd, m_rd, w_rd;
  always_ff @(posedge clk) begin
    if (f_we) fmem[f_wa] <= f_wd;
    if (p_we) pmem[p_wa] <= p_wd;
    if (m_we) mmem[m_wa] <= m_wd;
    if (w_we) wmem[w_wa] <= w_wd;
    f_rd <= fmem[f_ra];
    p_rd <= pmem[p_ra];
    m_rd <= mmem[m_ra];
    w_rd <= wmem[w_ra];
  end

  // Sequencer registers
  cnhs_pkg::state_t st_r, st_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic [31:0]   drv_r, drv_nxt;
  logic [31:0]   a_r, a_nxt;     // left neighbour / previous value
  logic [31:0]   b_r, b_nxt;     // centre value / multiplier
  logic [31:0]   c_r, c_nxt;     // right value / scratch
  logic [33:0]   d_r, d_nxt;     // running pivot
  logic signed [65:0] prod_r, prod_nxt;
  logic          ov_r, ov_nxt;
  logic [5:0]    oi_r, oi_nxt;
  logic [31:0]   ovl_r, ovl_nxt;
  logic          ol_r, ol_nxt;
  logic          clr_ok_r;       // field cleared by reset sweep done

  cnhs_pkg::div_req_t dreq;
  cnhs_pkg::div_rsp_t drsp;
  cnhs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Rounding shift, ties away from zero
  function automatic w_t rsr(input w_t v, input int s);
    w_t m;
    m = v[65] ? -v : v;
    m = (m + (w_t'(1) <<< (s - 1))) >>> s;
    return v[65] ? -m : m;
  endfunction

  localparam w_t ONE = w_t'(1) <<< FRAC_BITS;
  w_t lamw;
  logic [5:0] node;
  logic in_win;
  assign lamw   = w_t'({1'b0, lam_r});
  assign node   = 6'(idx_r) + 6'd1;
  assign in_win = (node >= src_lo_r) && (node <= src_hi_r);

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; ph_nxt = ph_r; drv_nxt = drv_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; prod_nxt = prod_r;
    ov_nxt = ov_r; oi_nxt = oi_r; ovl_nxt = ovl_r; ol_nxt = ol_r;
    f_ra = idx_r; p_ra = idx_r; m_ra = idx_r; w_ra = idx_r;
    f_wa = idx_r; p_wa = idx_r; m_wa = idx_r; w_wa = idx_r;
    f_we = 1'b0; p_we = 1'b0; m_we = 1'b0; w_we = 1'b0;
    f_wd = '0; p_wd = '0; m_wd = '0; w_wd = '0;
    dreq = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      cnhs_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          idx_nxt = '0; ph_nxt = '0; drv_nxt = in_tdata;
          st_nxt = (in_tuser == cnhs_pkg::CMD_STEP) ? cnhs_pkg::ST_RHS
                                                    : cnhs_pkg::ST_CLEAR;
        end
      end
      cnhs_pkg::ST_CLEAR: begin
        f_we = 1'b1;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == LASTA) st_nxt = cnhs_pkg::ST_IDLE;
      end
      // Right-hand side: window of three, neighbours outside are zero
      cnhs_pkg::ST_RHS: begin
        case (ph_r)
          3'd0: begin
            f_ra = idx_r; ph_nxt = 3'd1;
            a_nxt = (idx_r == '0) ? '0 : b_r;
          end
          3'd1: begin
            b_nxt = f_rd;
            f_ra = (idx_r == LASTA) ? idx_r : idx_r + AW'(1);
            ph_nxt = 3'd2;
          end
          3'd2: begin
            c_nxt = (idx_r == LASTA) ? '0 : f_rd;
            prod_nxt = (ONE - lamw) * 2 * w_t'($signed(b_r));
            ph_nxt = 3'd3;
          end
          3'd3: begin
            prod_nxt = prod_r + lamw * (w_t'($signed(a_r)) + w_t'($signed(c_r)));
            ph_nxt = 3'd4;
          end
          default: begin
            w_we = 1'b1;
            w_wd = cnhs_pkg::sat32(rsr(prod_r, FRAC_BITS + 1)
                   + (in_win ? w_t'($signed(drv_r)) : w_t'(0)));
            ph_nxt = 3'd0;
            idx_nxt = idx_r + AW'(1);
            if (idx_r == LASTA) begin
              idx_nxt = '0;
              d_nxt = 34'(ONE + lamw);
              st_nxt = cnhs_pkg::ST_FACT;
            end
          end
        endcase
      end
      // Factorisation: pivot, then multiplier by division
      cnhs_pkg::ST_FACT: begin
        case (ph_r)
          3'd0: begin
            p_we = 1'b1;
            p_wd = cnhs_pkg::sat32(w_t'($signed({1'b0, d_r})) < 1 ? w_t'(1)
                                   : w_t'($signed({1'b0, d_r})));
            c_nxt = p_wd;
            if (idx_r == LASTA) begin
              idx_nxt = AW'(1); st_nxt = cnhs_pkg::ST_FWD;
            end else ph_nxt = 3'd1;
          end
          3'd1: begin
            dreq.start = 1'b1;
            dreq.num = 64'(lamw * ONE);
            dreq.den = {1'b0, c_r, 1'b0};
            ph_nxt = 3'd2;
          end
          3'd2: begin
            if (drsp.done) begin
              m_we = 1'b1;
              m_wd = cnhs_pkg::sat32(-w_t'($signed(drsp.quo)));
              c_nxt = m_wd;
              ph_nxt = 3'd3;
            end
          end
          3'd3: begin
            prod_nxt = -w_t'($signed(c_r)) * lamw;
            ph_nxt = 3'd4;
          end
          default: begin
            d_nxt = 34'(ONE + lamw - rsr(prod_r, FRAC_BITS + 1));
            ph_nxt = 3'd0;
            idx_nxt = idx_r + AW'(1);
          end
        endcase
      end
      // Forward substitution, a_r carries w[i-1]
      cnhs_pkg::ST_FWD: begin
        case (ph_r)
          3'd0: begin
            w_ra = idx_r - AW'(1); m_ra = idx_r - AW'(1); ph_nxt = 3'd1;
          end
          3'd1: begin
            a_nxt = w_rd; b_nxt = m_rd; w_ra = idx_r; ph_nxt = 3'd2;
          end
          3'd2: begin
            c_nxt = w_rd;
            prod_nxt = w_t'($signed(b_r)) * w_t'($signed(a_r));
            ph_nxt = 3'd3;
          end
          default: begin
            w_we = 1'b1;
            w_wd = cnhs_pkg::sat32(w_t'($signed(c_r)) - rsr(prod_r, FRAC_BITS));
            ph_nxt = 3'd0;
            idx_nxt = idx_r + AW'(1);
            if (idx_r == LASTA) begin
              idx_nxt = '0; st_nxt = cnhs_pkg::ST_SCALE;
            end
          end
        endcase
      end
      // Scaling by pivots through the divider
      cnhs_pkg::ST_SCALE: begin
        case (ph_r)
          3'd0: ph_nxt = 3'd1;
          3'd1: begin
            dreq.start = 1'b1;
            dreq.num = 64'(w_t'($signed(w_rd)) * ONE);
            dreq.den = {2'b00, p_rd};
            ph_nxt = 3'd2;
          end
          default: begin
            if (drsp.done) begin
              w_we = 1'b1;
              w_wd = cnhs_pkg::sat32(w_t'($signed(drsp.quo)));
              ph_nxt = 3'd0;
              idx_nxt = idx_r + AW'(1);
              if (idx_r == LASTA) begin
                idx_nxt = LASTA; st_nxt = cnhs_pkg::ST_BACK;
              end
            end
          end
        endcase
      end
      // Back substitution from the top; last node copied straight
      cnhs_pkg::ST_BACK: begin
        case (ph_r)
          3'd0: begin
            w_ra = idx_r; ph_nxt = 3'd1;
          end
          3'd1: begin
            a_nxt = w_rd; f_we = 1'b1; f_wd = w_rd;
            if (idx_r == '0) begin
              idx_nxt = '0; st_nxt = cnhs_pkg::ST_EMIT;
            end else begin
              idx_nxt = idx_r - AW'(1); ph_nxt = 3'd2;
            end
          end
          3'd2: begin
            w_ra = idx_r; m_ra = idx_r; ph_nxt = 3'd3;
          end
          3'd3: begin
            c_nxt = w_rd;
            prod_nxt = w_t'($signed(m_rd)) * w_t'($signed(a_r));
            ph_nxt = 3'd4;
          end
          default: begin
            w_we = 1'b1;
            w_wd = cnhs_pkg::sat32(w_t'($signed(c_r)) - rsr(prod_r, FRAC_BITS));
            ph_nxt = 3'd0;
          end
        endcase
      end
      // Stream the new field out
      cnhs_pkg::ST_EMIT: begin
        f_ra = idx_r;
        if (!ov_nxt) st_nxt = cnhs_pkg::ST_WAIT;
      end
      cnhs_pkg::ST_WAIT: begin
        ov_nxt = 1'b1; oi_nxt = node; ovl_nxt = f_rd; ol_nxt = (idx_r == LASTA);
        idx_nxt = idx_r + AW'(1);
        st_nxt = (idx_r == LASTA) ? cnhs_pkg::ST_IDLE : cnhs_pkg::ST_EMIT;
      end
      default: st_nxt = cnhs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= cnhs_pkg::ST_CLEAR;
      idx_r <= '0;
      ph_r <= '0;
      ov_r <= 1'b0;
      clr_ok_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      ph_r <= ph_nxt;
      ov_r <= ov_nxt;
      if (st_r == cnhs_pkg::ST_IDLE) clr_ok_r <= 1'b1;
    end
    drv_r <= drv_nxt; a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt;
    prod_r <= prod_nxt; oi_r <= oi_nxt; ovl_r <= ovl_nxt; ol_r <= ol_nxt;
  end

  assign in_tready  = (st_r == cnhs_pkg::ST_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, ovl_r, oi_r};
  assign out_tlast  = ol_r;

`ifndef SYNTH
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != cnhs_pkg::ST_IDLE) |-> !in_tready) else $error("request taken while busy");
  a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_ok_r |-> !out_tvalid) else $error("result before reset sweep");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> (ov_r && $stable(oi_r))) else $error("result lost");
`endif

endmodule

[bench/heat_step_checker.sv]
`timescale 1ns / 1ps
// Watches the request, result and register ports; predicts each node value
module heat_step_checker #(
  parameter int GRID_INTERVALS = 32,
  parameter int FRAC_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_nodes
);
  localparam int NODES = GRID_INTERVALS - 1;

  typedef struct packed {
    logic [5:0]  index;
    logic [31:0] value;
    logic        last;
  } node_result_t;

  node_result_t expected_nodes[$];
  logic signed [31:0] field[NODES];
  logic [23:0] lambda;
  logic [5:0]  win_lo, win_hi;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round to nearest, ties away from zero
  function automatic longint shift_rnd(input longint v, input int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint div_rnd(input longint num, input longint den);
    longint m;
    m = (num < 0) ? -num : num;
    m = (m + den / 2) / den;
    return (num < 0) ? -m : m;
  endfunction

  // advance the field one step and queue the emitted nodes
  task automatic predict_step(input logic signed [31:0] drive);
    longint one, lam, acc, ul, ur, b, d, l, t;
    logic signed [31:0] w[NODES];
    logic signed [31:0] piv[NODES];
    logic signed [31:0] mul[NODES];
    node_result_t r;
    one = 64'sd1 <<< FRAC_BITS;
    lam = longint'(lambda);
    for (int i = 0; i < NODES; i++) begin
      ul = (i > 0) ? longint'(field[i-1]) : 0;
      ur = (i < NODES - 1) ? longint'(field[i+1]) : 0;
      acc = (one - lam) * 2 * longint'(field[i]) + lam * (ul + ur);
      b = shift_rnd(acc, FRAC_BITS + 1);
      if (i + 1 >= win_lo && i + 1 <= win_hi) b += longint'(drive);
      w[i] = clamp32(b);
    end
    d = one + lam;
    for (int i = 0; i < NODES; i++) begin
      if (d < 1) d = 1;
      piv[i] = clamp32(d);
      if (i < NODES - 1) begin
        l = -div_rnd(lam * one, 2 * longint'(piv[i]));
        mul[i] = clamp32(l);
        t = shift_rnd(-longint'(mul[i]) * lam, FRAC_BITS + 1);
        d = one + lam - t;
      end
    end
    for (int i = 1; i < NODES; i++)
      w[i] = clamp32(longint'(w[i]) - shift_rnd(longint'(mul[i-1]) * w[i-1], FRAC_BITS));
    for (int i = 0; i < NODES; i++)
      w[i] = clamp32(div_rnd(longint'(w[i]) * one, longint'(piv[i])));
    for (int i = NODES - 2; i >= 0; i--)
      w[i] = clamp32(longint'(w[i]) - shift_rnd(longint'(mul[i]) * w[i+1], FRAC_BITS));
    for (int i = 0; i < NODES; i++) begin
      field[i] = w[i];
      r.index = 6'(i + 1);
      r.value = w[i];
      r.last = (i == NODES - 1);
      expected_nodes.insert(expected_nodes.size(), r);
    end
  endtask

  always @(posedge clk) begin
    node_result_t want;
    if (!rst_n) begin
      fail_count <= 0;
      lambda = 24'd65536;
      win_lo = 6'd1;
      win_hi = 6'd1;
      for (int i = 0; i < NODES; i++) field[i] = '0;
      expected_nodes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cnhs_pkg::REG_LAMBDA: lambda = cfg_data;
          cnhs_pkg::REG_SRC_LO: win_lo = cfg_data[5:0];
          cnhs_pkg::REG_SRC_HI: win_hi = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == cnhs_pkg::CMD_CLEAR) begin
          for (int i = 0; i < NODES; i++) field[i] = '0;
        end else begin
          predict_step(in_tdata);
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_nodes.size() == 0) begin
          $display("%0t: unexpected node result %h last %b", $time, out_tdata, out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_nodes.pop_front();
          if (out_tdata[5:0] !== want.index || out_tdata[37:6] !== want.value ||
              out_tdata[39:38] !== 2'b00 || out_tlast !== want.last) begin
            $display("%0t: expected node %0d value %h last %b, got node %0d value %h last %b",
                     $time, want.index, want.value, want.last,
                     out_tdata[5:0], out_tdata[37:6], out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_nodes <= expected_nodes.size();
  end
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;

  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam logic [1:0] REG_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending_nodes;
  longint      cycles = 0;
  int          burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  crank_nicolson_heat_step_unit dut (.*);
  heat_step_checker checker_i (.*);

  // receiver stall pattern: stretches of free flow, stretches of random stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if ((cycles % 2000) < 700) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one request, with a random gap ahead when a burst runs out
  task automatic send_request(input logic cmd, input logic [31:0] drive);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = $urandom_range(0, 30);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= drive;
    do @(posedge clk); while (!in_tready);
  endtask

  // wait for all node results, then for a clear sweep to finish
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_nodes != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_drive;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 262144)) - 131072);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 8388608)) - 4194304);
    endcase
  endfunction

  initial begin
    logic [23:0] lam_set[6];
    lam_set = '{24'd0, 24'hffffff, 24'd65536, 24'd32768, 24'd1, 24'd400000};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, extremes of drive, clears
    send_request(cnhs_pkg::CMD_STEP, 32'h00010000);
    send_request(cnhs_pkg::CMD_STEP, 32'h7fffffff);
    send_request(cnhs_pkg::CMD_STEP, 32'h7fffffff);
    send_request(cnhs_pkg::CMD_CLEAR, 32'hffffffff);
    send_request(cnhs_pkg::CMD_STEP, 32'h80000000);
    send_request(cnhs_pkg::CMD_STEP, 32'h00000000);
    drain();
    write_reg(cnhs_pkg::REG_LAMBDA, 24'hffffff);
    write_reg(cnhs_pkg::REG_SRC_LO, 24'd1);
    write_reg(cnhs_pkg::REG_SRC_HI, 24'd63);
    send_request(cnhs_pkg::CMD_STEP, 32'h7fffffff);
    send_request(cnhs_pkg::CMD_STEP, 32'h80000000);
    drain();
    write_reg(cnhs_pkg::REG_LAMBDA, 24'd0);
    write_reg(cnhs_pkg::REG_SRC_LO, 24'd20);
    write_reg(cnhs_pkg::REG_SRC_HI, 24'd5);
    send_request(cnhs_pkg::CMD_STEP, 32'h00030000);
    drain();
    write_reg(cnhs_pkg::REG_SRC_LO, 24'd0);
    write_reg(cnhs_pkg::REG_SRC_HI, 24'd0);
    send_request(cnhs_pkg::CMD_STEP, 32'h00030000);
    drain();
    write_reg(cnhs_pkg::REG_SRC_LO, 24'd63);
    write_reg(cnhs_pkg::REG_SRC_HI, 24'd63);
    write_reg(REG_UNKNOWN, 24'h5a5a5a);
    send_request(cnhs_pkg::CMD_STEP, 32'h12345678);
    send_request(cnhs_pkg::CMD_CLEAR, 32'h0);
    drain();

    // random phases, each with fresh register values
    for (int ph = 0; ph < 25; ph++) begin
      if (ph < 6) write_reg(cnhs_pkg::REG_LAMBDA, lam_set[ph]);
      else write_reg(cnhs_pkg::REG_LAMBDA,
                     24'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 300000)));
      write_reg(cnhs_pkg::REG_SRC_LO, 24'($urandom_range(0, 63)));
      write_reg(cnhs_pkg::REG_SRC_HI, 24'($urandom_range(0, 63)));
      for (int k = 0; k < 20; k++)
        send_request(($urandom_range(0, 9) != 0) ? cnhs_pkg::CMD_STEP : cnhs_pkg::CMD_CLEAR,
                     rand_drive());
      drain();
    end

    drain();
    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
